// File: rtl/core/bpfl_pkg.sv
package bpfl_pkg;

    localparam int MAX_CHUNKS_DEF = 8;
    localparam int MAX_BPC_DEF    = 128;

    localparam int MODE_W     = 2;
    localparam int IDX_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int OFF_W      = 22;
    localparam int CNT_W      = 11;
    localparam int CHUNK_W    = 4;
    localparam int BPC_W      = 8;
    localparam int ELEM_W     = 13;
    localparam int ALIGN_W    = 3;
    localparam int TOTAL_W    = 12;
    localparam int STRIDE_W   = 13;
    localparam int EPOCH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPC         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = 2'd3;

    localparam logic [ELEM_W-1:0]  ELEM_RST  = 13'd8;
    localparam logic [ALIGN_W-1:0] ALIGN_RST = 3'd3;
    localparam logic [BPC_W-1:0]   BPC_RST   = 8'd128;
    localparam logic [CHUNK_W-1:0] LIMIT_RST = 4'd8;

    localparam logic [CNT_W-1:0] FREE_CAP = 11'd2047;

    typedef struct packed {
        logic accept;
        logic commit;
        logic rebuild;
        logic sweep_init;
        logic sweep_step;
    } t_dp_cmd;

    typedef struct packed {
        logic epoch_wrap;
        logic clear_wrap;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/core/block_pool_free_list_allocator.sv
// channel   | direction | transfer on          | payload
// s_axis    | in        | tvalid & tready      | tuser mode, tdata release_index
// m_axis    | out       | tvalid & tready      | tuser status, tdata result counts
// cfg       | in        | i_cfg_we             | i_cfg_idx register, i_cfg_data value
//
// each item is handled as head lookup and link store read, then list update
// the list update waits on the link store read made before each head move
// after reset, and after every 255th pool rebuild or clear, a tag sweep over
// every link store entry runs with s_axis_tready low
// a configuration write holds s_axis_tready low while the pool is rebuilt
// a result waits in the output register; one more item may be taken and waits behind it
module block_pool_free_list_allocator
    import bpfl_pkg::*;
#(
    parameter int MAX_CHUNKS           = MAX_CHUNKS_DEF,
    parameter int MAX_BLOCKS_PER_CHUNK = MAX_BPC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // release_index
    input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // granted_index, granted_offset,
                                                 // free_blocks, used_blocks, chunks_present
    output logic [STATUS_W-1:0]   m_axis_tuser,  // status
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [IDX_W-1:0]   granted_index;
    logic [OFF_W-1:0]   granted_offset;
    logic [CNT_W-1:0]   free_blocks;
    logic [CNT_W-1:0]   used_blocks;
    logic [CHUNK_W-1:0] chunks_present;

    bpfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpfl_dp #(
        .MAX_CHUNKS           (MAX_CHUNKS),
        .MAX_BLOCKS_PER_CHUNK (MAX_BLOCKS_PER_CHUNK)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (s_axis_tuser),
        .i_release_index  (s_axis_tdata[IDX_W-1:0]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_status         (m_axis_tuser),
        .o_granted_index  (granted_index),
        .o_granted_offset (granted_offset),
        .o_free_blocks    (free_blocks),
        .o_used_blocks    (used_blocks),
        .o_chunks_present (chunks_present),
        .i_cmd            (cmd),
        .o_stat           (stat)
    );

    assign m_axis_tdata = {6'd0, chunks_present, used_blocks, free_blocks,
                           granted_offset, granted_index};

endmodule

// File: rtl/core/bpfl_ctrl.sv
module bpfl_ctrl
    import bpfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_cfg_pend;
    logic       n_cfg_pend;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_cfg_pend = r_cfg_pend;
        case (r_state)
            ST_SWEEP: begin
                if (r_cfg_pend) begin
                    o_cmd.rebuild    = 1'b1;
                    o_cmd.sweep_init = 1'b1;
                    n_cfg_pend       = 1'b0;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                    if (i_stat.sweep_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (r_cfg_pend) begin
                    o_cmd.rebuild = 1'b1;
                    n_cfg_pend    = 1'b0;
                    if (i_stat.epoch_wrap) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = ST_SWEEP;
                    end
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                    if (i_stat.clear_wrap) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = ST_SWEEP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_cfg_pend = 1'b1;
        end
    end

    // reset starts with a pending rebuild so the first sweep also sets up the pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SWEEP;
            r_cfg_pend <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_cfg_pend <= n_cfg_pend;
        end
    end

endmodule

// File: rtl/core/bpfl_dp.sv
module bpfl_dp
    import bpfl_pkg::*;
#(
    parameter int MAX_CHUNKS           = MAX_CHUNKS_DEF,
    parameter int MAX_BLOCKS_PER_CHUNK = MAX_BPC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [IDX_W-1:0]      i_release_index,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]      o_granted_index,
    output logic [OFF_W-1:0]      o_granted_offset,
    output logic [CNT_W-1:0]      o_free_blocks,
    output logic [CNT_W-1:0]      o_used_blocks,
    output logic [CHUNK_W-1:0]    o_chunks_present,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int TOTAL     = MAX_CHUNKS * MAX_BLOCKS_PER_CHUNK;
    localparam int SLOT_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int WORD_W    = EPOCH_W + SLOT_W;
    localparam int PROD_W    = SLOT_W + STRIDE_W;
    localparam int BPC_CAPI  = (MAX_BLOCKS_PER_CHUNK < 255) ? MAX_BLOCKS_PER_CHUNK : 255;
    localparam int LIM_CAPI  = (MAX_CHUNKS < 15) ? MAX_CHUNKS : 15;
    localparam bit IDX_FITS  = (TOTAL >= (1 << IDX_W));

    localparam logic [BPC_W-1:0]   BPC_CAP   = BPC_W'(BPC_CAPI);
    localparam logic [CHUNK_W-1:0] LIM_CAP   = CHUNK_W'(LIM_CAPI);
    localparam logic [IDX_W-1:0]   IDX_LIMIT = IDX_W'(TOTAL);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(TOTAL - 1);

    // configuration
    logic [ELEM_W-1:0]   r_elem;
    logic [ALIGN_W-1:0]  r_align;
    logic [BPC_W-1:0]    r_bpc;
    logic [CHUNK_W-1:0]  r_limit;
    logic [STRIDE_W-1:0] r_stride;
    logic [STRIDE_W-1:0] n_stride;

    // pool state
    logic [SLOT_W-1:0]  r_head;
    logic [SLOT_W-1:0]  n_head;
    logic [CNT_W-1:0]   r_free;
    logic [CNT_W-1:0]   n_free;
    logic [CHUNK_W-1:0] r_chunks;
    logic [CHUNK_W-1:0] n_chunks;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [EPOCH_W-1:0] r_epoch;
    logic [SLOT_W-1:0]  r_sweep;

    // item in flight
    logic [MODE_W-1:0] r_mode;
    logic [IDX_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_h;
    logic              r_grow;
    logic              r_exh;

    // link store with write epoch per entry
    logic [WORD_W-1:0] mem [TOTAL];
    logic [WORD_W-1:0] r_rd;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_gidx;
    logic [OFF_W-1:0]    r_goff;
    logic [CNT_W-1:0]    r_ofree;
    logic [CNT_W-1:0]    r_oused;
    logic [CHUNK_W-1:0]  r_ochunks;

    logic [STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]    n_gidx;
    logic [OFF_W-1:0]    n_goff;
    logic [CNT_W-1:0]    n_used;

    logic [BPC_W-1:0]    bpc_eff;
    logic [CHUNK_W-1:0]  lim_eff;
    logic [ELEM_W-1:0]   elem_c;
    logic [ALIGN_W-1:0]  align_c;
    logic [STRIDE_W-1:0] align_mask;
    logic                grow;
    logic [SLOT_W-1:0]   h_sel;
    logic [TOTAL_W-1:0]  grow_top;
    logic [PROD_W-1:0]   prod;
    logic                range_err;
    logic                link_ok;
    logic [SLOT_W-1:0]   idx_slot;
    logic [SLOT_W-1:0]   rb_head;
    logic                out_free;
    logic                commit_free;

    assign bpc_eff = (r_bpc == '0) ? BPC_W'(1) : ((r_bpc > BPC_CAP) ? BPC_CAP : r_bpc);
    assign lim_eff = (r_limit == '0) ? CHUNK_W'(1)
                   : ((r_limit > LIM_CAP) ? LIM_CAP : r_limit);

    always_comb begin
        elem_c = r_elem;
        if (elem_c > ELEM_W'(4096)) begin
            elem_c = ELEM_W'(4096);
        end
        if (elem_c < ELEM_W'(8)) begin
            elem_c = ELEM_W'(8);
        end
        align_c    = (r_align > ALIGN_W'(6)) ? ALIGN_W'(6) : r_align;
        align_mask = (STRIDE_W'(1) << align_c) - STRIDE_W'(1);
        n_stride   = (STRIDE_W'(elem_c) + align_mask) & ~align_mask;
    end

    // head chosen at transfer time; a new chunk is opened when the list is empty and the chunk limit allows
    assign grow     = (r_free == '0);
    assign grow_top = r_total + TOTAL_W'(bpc_eff) - TOTAL_W'(1);
    assign h_sel    = grow ? SLOT_W'(grow_top) : r_head;
    assign rb_head  = SLOT_W'(bpc_eff - BPC_W'(1));

    assign prod      = PROD_W'(r_h) * PROD_W'(r_stride);
    assign idx_slot  = SLOT_W'(r_idx);
    assign range_err = (TOTAL_W'(r_idx) >= r_total) || (!IDX_FITS && (r_idx >= IDX_LIMIT));
    assign link_ok   = (r_rd[WORD_W-1:SLOT_W] == r_epoch);
    assign out_free  = !r_out_valid || i_out_ready;

    assign commit_free = i_cmd.commit && (r_mode == MODE_FREE) && !range_err;
    assign mem_we      = i_cmd.sweep_step || commit_free;
    assign mem_waddr   = i_cmd.sweep_step ? r_sweep : idx_slot;
    assign mem_wdata   = i_cmd.sweep_step ? '0 : {r_epoch, r_head};

    always_comb begin
        n_head   = r_head;
        n_free   = r_free;
        n_chunks = r_chunks;
        n_total  = r_total;
        n_status = STAT_OK;
        n_gidx   = '0;
        n_goff   = '0;
        if (i_cmd.commit) begin
            case (r_mode)
                MODE_ALLOC: begin
                    if (r_exh) begin
                        n_status = STAT_EXHAUSTED;
                    end else begin
                        if (r_grow) begin
                            n_chunks = r_chunks + CHUNK_W'(1);
                            n_total  = r_total + TOTAL_W'(bpc_eff);
                            n_free   = CNT_W'(bpc_eff) - CNT_W'(1);
                        end else begin
                            n_free = r_free - CNT_W'(1);
                        end
                        if (link_ok) begin
                            n_head = r_rd[SLOT_W-1:0];
                        end else begin
                            n_head = (r_h != '0) ? r_h - SLOT_W'(1) : '0;
                        end
                        n_gidx = IDX_W'(r_h);
                        n_goff = OFF_W'(prod);
                    end
                end
                MODE_FREE: begin
                    if (range_err) begin
                        n_status = STAT_RANGE;
                    end else begin
                        n_head = idx_slot;
                        n_free = (r_free == FREE_CAP) ? r_free : r_free + CNT_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    n_head   = rb_head;
                    n_free   = CNT_W'(bpc_eff);
                    n_chunks = CHUNK_W'(1);
                    n_total  = TOTAL_W'(bpc_eff);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.rebuild) begin
            n_head   = rb_head;
            n_free   = CNT_W'(bpc_eff);
            n_chunks = CHUNK_W'(1);
            n_total  = TOTAL_W'(bpc_eff);
        end
        n_used = (n_total > TOTAL_W'(n_free)) ? CNT_W'(n_total - TOTAL_W'(n_free)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem  <= ELEM_RST;
            r_align <= ALIGN_RST;
            r_bpc   <= BPC_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ELEM_BYTES:  r_elem  <= i_cfg_data[ELEM_W-1:0];
                CFG_ALIGN_LOG2:  r_align <= i_cfg_data[ALIGN_W-1:0];
                CFG_BPC:         r_bpc   <= i_cfg_data[BPC_W-1:0];
                CFG_CHUNK_LIMIT: r_limit <= i_cfg_data[CHUNK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_free      <= '0;
            r_chunks    <= '0;
            r_total     <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_free   <= n_free;
            r_chunks <= n_chunks;
            r_total  <= n_total;
            if (i_cmd.sweep_init) begin
                r_epoch <= EPOCH_W'(1);
            end else if (i_cmd.rebuild || (i_cmd.commit && r_mode == MODE_CLEAR)) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.sweep_init) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + SLOT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_idx  <= i_release_index;
            r_h    <= h_sel;
            r_grow <= grow;
            r_exh  <= grow && (r_chunks >= lim_eff);
        end
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_gidx    <= n_gidx;
            r_goff    <= n_goff;
            r_ofree   <= n_free;
            r_oused   <= n_used;
            r_ochunks <= n_chunks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd <= mem[h_sel];
        end
    end

    assign o_stat.epoch_wrap = (r_epoch == '1);
    assign o_stat.clear_wrap = (r_mode == MODE_CLEAR) && (r_epoch == '1);
    assign o_stat.sweep_last = (r_sweep == SLOT_LAST);
    assign o_stat.out_free   = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_index  = r_gidx;
    assign o_granted_offset = r_goff;
    assign o_free_blocks    = r_ofree;
    assign o_used_blocks    = r_oused;
    assign o_chunks_present = r_ochunks;

endmodule

// File: rtl/core/bpfl_chk.sv
module bpfl_chk
    import bpfl_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser,
    input logic                  i_cfg_we
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // a configuration write rebuilds the pool before the next transfer
    a_cfg_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input taken during pool rebuild");

    // failed operations grant nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[31:0] == 32'd0)
        else $error("grant on failed operation");

    // the pool always holds at least one chunk
    a_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:54] != 4'd0)
        else $error("empty pool reported");

endmodule

bind block_pool_free_list_allocator bpfl_chk u_chk (.*);

// File: sim/block_pool_free_list_allocator_tb.sv
module block_pool_free_list_allocator_tb;
    import bpfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SLOTS = MAX_CHUNKS_DEF * MAX_BPC_DEF;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
        logic [OFF_W-1:0]    granted_offset;
        logic [CNT_W-1:0]    free_blocks;
        logic [CNT_W-1:0]    used_blocks;
        logic [CHUNK_W-1:0]  chunks_present;
    } t_pool_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    block_pool_free_list_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // pool copy kept by the testbench
    int unsigned cfg_elem;
    int unsigned cfg_align;
    int unsigned cfg_bpc;
    int unsigned cfg_limit;
    int unsigned top_of_list;
    int unsigned next_link [SLOTS];
    bit          link_valid [SLOTS];
    int unsigned chunks_now;
    int unsigned free_now;

    t_pool_reply pending_replies[$];
    int unsigned blocks_held[$];
    int          fail_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned blocks_per_chunk_eff();
        if (cfg_bpc < 1) return 1;
        if (cfg_bpc > MAX_BPC_DEF) return MAX_BPC_DEF;
        return cfg_bpc;
    endfunction

    function automatic int unsigned chunk_limit_eff();
        if (cfg_limit < 1) return 1;
        if (cfg_limit > MAX_CHUNKS_DEF) return MAX_CHUNKS_DEF;
        return cfg_limit;
    endfunction

    function automatic int unsigned block_stride();
        int unsigned e;
        int unsigned a;
        e = cfg_elem;
        a = 1 << ((cfg_align > 6) ? 6 : cfg_align);
        if (e < 1) e = 1;
        if (e > 4096) e = 4096;
        if (e < 8) e = 8;
        return (e + a - 1) & ~(a - 1);
    endfunction

    function automatic void rebuild_pool();
        foreach (link_valid[i]) link_valid[i] = 1'b0;
        chunks_now = 1;
        top_of_list = blocks_per_chunk_eff() - 1;
        free_now = blocks_per_chunk_eff();
        blocks_held.delete();
    endfunction

    function automatic void predict_pool_step(logic [MODE_W-1:0] mode,
                                              logic [IDX_W-1:0] idx);
        t_pool_reply r;
        int unsigned bpc;
        int unsigned h;
        int unsigned total;
        bpc = blocks_per_chunk_eff();
        r.status = STAT_OK;
        r.granted_index = '0;
        r.granted_offset = '0;
        case (mode)
            MODE_ALLOC: begin
                if (free_now == 0 && chunks_now >= chunk_limit_eff()) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    if (free_now == 0) begin
                        top_of_list = chunks_now * bpc + bpc - 1;
                        free_now = bpc;
                        chunks_now++;
                    end
                    h = top_of_list % SLOTS;
                    r.granted_index = h[IDX_W-1:0];
                    r.granted_offset = OFF_W'(h * block_stride());
                    top_of_list = link_valid[h] ? next_link[h] : ((h > 0) ? h - 1 : 0);
                    free_now--;
                    blocks_held.push_back(h);
                end
            end
            MODE_FREE: begin
                if (idx >= chunks_now * bpc) begin
                    r.status = STAT_RANGE;
                end else begin
                    next_link[idx] = top_of_list;
                    link_valid[idx] = 1'b1;
                    top_of_list = idx;
                    if (free_now < FREE_CAP) free_now++;
                end
            end
            MODE_CLEAR: rebuild_pool();
            default: ;
        endcase
        total = chunks_now * bpc;
        r.free_blocks = free_now[CNT_W-1:0];
        r.used_blocks = (total > free_now) ? CNT_W'(total - free_now) : '0;
        r.chunks_present = chunks_now[CHUNK_W-1:0];
        pending_replies.push_back(r);
    endfunction

    // receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (holds_served != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pool_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[9:0] !== want.granted_index) begin
                    $error("granted_index expected %0d got %0d",
                           want.granted_index, m_axis_tdata[9:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:10] !== want.granted_offset) begin
                    $error("granted_offset expected %0d got %0d",
                           want.granted_offset, m_axis_tdata[31:10]);
                    fail_count++;
                end
                if (m_axis_tdata[42:32] !== want.free_blocks) begin
                    $error("free_blocks expected %0d got %0d",
                           want.free_blocks, m_axis_tdata[42:32]);
                    fail_count++;
                end
                if (m_axis_tdata[53:43] !== want.used_blocks) begin
                    $error("used_blocks expected %0d got %0d",
                           want.used_blocks, m_axis_tdata[53:43]);
                    fail_count++;
                end
                if (m_axis_tdata[57:54] !== want.chunks_present) begin
                    $error("chunks_present expected %0d got %0d",
                           want.chunks_present, m_axis_tdata[57:54]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {{(IN_DATA_W-IDX_W){1'b0}}, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pool_step(mode, idx);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        case (idx)
            CFG_ELEM_BYTES:  cfg_elem = value & 13'h1fff;
            CFG_ALIGN_LOG2:  cfg_align = value & 3'h7;
            CFG_BPC:         cfg_bpc = value & 8'hff;
            CFG_CHUNK_LIMIT: cfg_limit = value & 4'hf;
            default: ;
        endcase
        rebuild_pool();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pool(int unsigned elem, int unsigned align,
                            int unsigned bpc, int unsigned limit);
        write_register(CFG_ELEM_BYTES, elem);
        write_register(CFG_ALIGN_LOG2, align);
        write_register(CFG_BPC, bpc);
        write_register(CFG_CHUNK_LIMIT, limit);
    endtask

    task automatic test_defaults();
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd127);
        send_request(MODE_FREE, 10'd1023);
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_UNUSED, 10'h2aa);
        send_request(MODE_CLEAR, 10'h155);
        send_request(MODE_ALLOC, '0);
        drain_replies();
    endtask

    // one block per chunk, growth and exhaustion, double free
    task automatic test_exhaust();
        set_pool(4096, 6, 1, 2);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_FREE, 10'd2);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_CLEAR, '0);
        drain_replies();
    endtask

    task automatic test_register_clamps();
        set_pool(0, 7, 0, 0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd0);
        drain_replies();
        set_pool(8191, 7, 255, 15);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd1023);
        drain_replies();
    endtask

    task automatic random_request();
        int unsigned r;
        int unsigned k;
        logic [IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        idx = IDX_W'($urandom());
        if (r < 86 && r >= 52 && blocks_held.size() != 0) begin
            k = $urandom_range(0, blocks_held.size() - 1);
            idx = IDX_W'(blocks_held[k]);
            blocks_held.delete(k);
            send_request(MODE_FREE, idx);
        end else if (r < 86) begin
            send_request(MODE_ALLOC, idx);
        end else if (r < 93) begin
            send_request(MODE_FREE, idx);
        end else if (r < 97) begin
            send_request(MODE_CLEAR, idx);
        end else begin
            send_request(MODE_UNUSED, idx);
        end
    endtask

    task automatic test_backpressure();
        set_pool(24, 4, 6, 3);
        holds_asked++;
        repeat (60) random_request();
        drain_replies();
        repeat (20) random_request();
        drain_replies();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: set_pool(1, 0, 1, 1);
                1: set_pool(4096, 6, 128, 8);
                default: set_pool($urandom_range(0, 8191), $urandom_range(0, 7),
                                  ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                                              : $urandom_range(0, 255),
                                  $urandom_range(0, 15));
            endcase
            repeat (140) random_request();
            drain_replies();
        end
    endtask

    initial begin
        cfg_elem = ELEM_RST;
        cfg_align = ALIGN_RST;
        cfg_bpc = BPC_RST;
        cfg_limit = LIMIT_RST;
        rebuild_pool();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_exhaust();
        test_register_clamps();
        tx_idle_pct = 23;
        rx_idle_pct = 59;
        test_backpressure();
        test_random_traffic(23, 59);
        test_random_traffic(59, 23);
        test_random_traffic(0, 0);
        drain_replies();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
